/* sv/ppa_pkg.sv */
// ----------------------------------------------------------------------------
// ppa_pkg
// shared types, constants and the phase table builder for the accumulator
// ----------------------------------------------------------------------------
`default_nettype none
package ppa_pkg;

	localparam int MAX_EIGVECS      = 64;
	localparam int MAX_EXTENT       = 64;
	localparam int PHASE_TABLE_BITS = 10;
	localparam int COLOURS          = 3;
	localparam int IDX_W            = $clog2(MAX_EIGVECS);
	localparam int ACC_AW           = 2 * IDX_W;
	localparam int ACC_DEPTH        = MAX_EIGVECS * MAX_EIGVECS;
	localparam int QTR              = (1 << PHASE_TABLE_BITS) / 4;
	localparam int QTR_W            = PHASE_TABLE_BITS - 2;
	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

	// opcodes of the input stream
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	// status codes of a result
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	// config register indexes
	localparam logic [2:0] CFG_STEP_X = 3'd0;
	localparam logic [2:0] CFG_STEP_Y = 3'd1;
	localparam logic [2:0] CFG_STEP_Z = 3'd2;
	localparam logic [2:0] CFG_EXT_Y  = 3'd3;
	localparam logic [2:0] CFG_EXT_Z  = 3'd4;
	localparam logic [2:0] CFG_NVEC   = 3'd5;
	localparam logic [2:0] CFG_UNITY  = 3'd6;

	// command kinds passed from front to back
	localparam logic [1:0] CMD_IMM   = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	typedef logic [16:0] qtab_t [QTR];

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         status;
		logic               one;
		logic [IDX_W-1:0]   col_j;
		logic signed [16:0] pc;
		logic signed [16:0] pd;
		logic signed [15:0] vr;
		logic signed [15:0] vi;
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
	} cmd_t;

	function automatic logic [16:0] to_q15(input longint v);
		longint t;
		t = (v < 0) ? 0 : v;
		t = (t + 16384) >>> 15;
		if (t > 32768) t = 32768;
		return t[16:0];
	endfunction

	// restoring shift and subtract quotient, used only while building tables
	function automatic longint unsigned div_u64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo, rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// quarter-wave table, Taylor series in Q30
	function automatic qtab_t build_tab(input bit want_cos);
		qtab_t tab;
		longint unsigned x, term;
		longint s, c;
		int n;
		for (int r = 0; r < QTR; r++) begin
			x = (PI_HALF_Q30 * 4 * longint'(r)) >> PHASE_TABLE_BITS;
			term = x;
			s = longint'(x);
			for (n = 1; n < 24 && term != 0; n++) begin
				term = div_u64((((term * x) >> 30) * x) >> 30,
					64'((2 * n) * (2 * n + 1)));
				s = (n % 2 == 1) ? s - longint'(term) : s + longint'(term);
			end
			term = 64'd1 << 30;
			c = longint'(64'd1 << 30);
			for (n = 1; n < 24 && term != 0; n++) begin
				term = div_u64((((term * x) >> 30) * x) >> 30,
					64'((2 * n - 1) * (2 * n)));
				c = (n % 2 == 1) ? c - longint'(term) : c + longint'(term);
			end
			tab[r] = want_cos ? to_q15(c) : to_q15(s);
		end
		return tab;
	endfunction

	function automatic logic [6:0] clamp_cnt(input logic [6:0] v, input logic [6:0] hi);
		if (v == 7'd0) return 7'd1;
		return (v > hi) ? hi : v;
	endfunction

endpackage
`default_nettype wire

/* sv/ppa_queue.sv */
// ----------------------------------------------------------------------------
// ppa_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module ppa_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire ppa_pkg::cmd_t push_cmd,
	output logic               ready,
	input  wire logic          pop,
	output logic               valid,
	output ppa_pkg::cmd_t      head
);
	ppa_pkg::cmd_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign ready = (cnt_q != 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

/* sv/ppa_front.sv */
// ----------------------------------------------------------------------------
// ppa_front
// config registers, site and colour counters, phase lookup, command build
// ----------------------------------------------------------------------------
`default_nettype none
module ppa_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_idx,
	input  wire logic [23:0]   cfg_data,
	input  wire logic          acc,
	input  wire logic [1:0]    opcode,
	input  wire logic [15:0]   elem_re,
	input  wire logic [15:0]   elem_im,
	input  wire logic [5:0]    row_sel,
	input  wire logic [5:0]    col_sel,
	output ppa_pkg::cmd_t      cmd
);
	localparam int PTB = ppa_pkg::PHASE_TABLE_BITS;
	localparam ppa_pkg::qtab_t COS_TAB = ppa_pkg::build_tab(1'b1);
	localparam ppa_pkg::qtab_t SIN_TAB = ppa_pkg::build_tab(1'b0);

	logic [23:0] step_x_q, step_y_q, step_z_q;
	logic [6:0]  ext_y_q, ext_z_q, nvec_q;
	logic        unity_q;
	logic [6:0]  col_cnt_q;
	logic [1:0]  colour_q;
	logic [5:0]  z_q, y_q;
	logic [23:0] phase_q, row_base_q, plane_base_q;

	logic [6:0]  n, ez, ey;
	logic [5:0]  j;
	logic [PTB-1:0] idx;
	logic [1:0]  quad;
	logic signed [16:0] cs, sn, co, si;
	logic        do_load;
	logic [23:0] row_next, plane_next;

	always_comb begin
		n   = ppa_pkg::clamp_cnt(nvec_q, 7'(ppa_pkg::MAX_EIGVECS));
		ez  = ppa_pkg::clamp_cnt(ext_z_q, 7'(ppa_pkg::MAX_EXTENT));
		ey  = ppa_pkg::clamp_cnt(ext_y_q, 7'(ppa_pkg::MAX_EXTENT));
		j   = (col_cnt_q >= n) ? 6'd0 : col_cnt_q[5:0];
		idx = phase_q[23 -: PTB];
		quad = idx[PTB-1 -: 2];
		cs  = COS_TAB[idx[ppa_pkg::QTR_W-1:0]];
		sn  = SIN_TAB[idx[ppa_pkg::QTR_W-1:0]];
		case (quad)
			2'd0: begin co = cs;  si = sn;  end
			2'd1: begin co = -sn; si = cs;  end
			2'd2: begin co = -cs; si = -sn; end
			default: begin co = sn; si = -cs; end
		endcase
		do_load = acc && (opcode == ppa_pkg::OP_LOAD) && !unity_q;
		row_next   = row_base_q + step_y_q;
		plane_next = plane_base_q + step_x_q;

		cmd = '0;
		cmd.vr    = elem_re;
		cmd.vi    = elem_im;
		cmd.row   = row_sel;
		cmd.col   = col_sel;
		cmd.col_j = j;
		cmd.pc    = co;
		cmd.pd    = -si;
		cmd.status = ppa_pkg::ST_OK;
		unique case (opcode)
			ppa_pkg::OP_LOAD:
				cmd.kind = unity_q ? ppa_pkg::CMD_IMM : ppa_pkg::CMD_LOAD;
			ppa_pkg::OP_READ: begin
				if ({1'b0, row_sel} >= n || {1'b0, col_sel} >= n) begin
					cmd.kind   = ppa_pkg::CMD_IMM;
					cmd.status = ppa_pkg::ST_RANGE;
				end else if (unity_q) begin
					cmd.kind = ppa_pkg::CMD_IMM;
					cmd.one  = (row_sel == col_sel);
				end else begin
					cmd.kind = ppa_pkg::CMD_READ;
				end
			end
			ppa_pkg::OP_START: cmd.kind = ppa_pkg::CMD_CLEAR;
			default:           cmd.kind = ppa_pkg::CMD_IMM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q <= '0; step_y_q <= '0; step_z_q <= '0;
			ext_y_q <= 7'd1; ext_z_q <= 7'd1; nvec_q <= 7'd1;
			unity_q <= 1'b0;
			col_cnt_q <= '0; colour_q <= '0; z_q <= '0; y_q <= '0;
			phase_q <= '0; row_base_q <= '0; plane_base_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					ppa_pkg::CFG_STEP_X: step_x_q <= cfg_data;
					ppa_pkg::CFG_STEP_Y: step_y_q <= cfg_data;
					ppa_pkg::CFG_STEP_Z: step_z_q <= cfg_data;
					ppa_pkg::CFG_EXT_Y:  ext_y_q  <= cfg_data[6:0];
					ppa_pkg::CFG_EXT_Z:  ext_z_q  <= cfg_data[6:0];
					ppa_pkg::CFG_NVEC:   nvec_q   <= cfg_data[6:0];
					ppa_pkg::CFG_UNITY:  unity_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (acc && opcode == ppa_pkg::OP_START) begin
				col_cnt_q <= '0; colour_q <= '0; z_q <= '0; y_q <= '0;
				phase_q <= '0; row_base_q <= '0; plane_base_q <= '0;
			end else if (do_load) begin
				if (7'(j) + 7'd1 < n) begin
					col_cnt_q <= 7'(j) + 7'd1;
				end else begin
					col_cnt_q <= '0;
					if (colour_q + 2'd1 < 2'(ppa_pkg::COLOURS)) begin
						colour_q <= colour_q + 2'd1;
					end else begin
						colour_q <= '0;
						// next site, z fastest
						if ({1'b0, z_q} + 7'd1 < ez) begin
							z_q <= z_q + 6'd1;
							phase_q <= phase_q + step_z_q;
						end else begin
							z_q <= '0;
							if ({1'b0, y_q} + 7'd1 < ey) begin
								y_q <= y_q + 6'd1;
								row_base_q <= row_next;
								phase_q <= row_next;
							end else begin
								y_q <= '0;
								plane_base_q <= plane_next;
								row_base_q <= plane_next;
								phase_q <= plane_next;
							end
						end
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

/* sv/ppa_back.sv */
// ----------------------------------------------------------------------------
// ppa_back
// accumulator memory, multiply-accumulate pipeline, clear pass and results
// ----------------------------------------------------------------------------
`default_nettype none
module ppa_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire ppa_pkg::cmd_t q_head,
	output logic               q_pop,
	output logic               clearing,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [103:0]       m_tdata
);
	localparam int AW = ppa_pkg::ACC_AW;
	localparam int IW = ppa_pkg::IDX_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RUN   = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_RDW   = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;
	localparam logic [2:0] S_CLR   = 3'd6;

	localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

	logic [2:0]    state_q;
	ppa_pkg::cmd_t cmd_q;
	logic [IW:0]   k_q;
	logic [AW-1:0] clr_cnt_q;
	logic          resp_pend_q;

	// memories: accumulator {sat, im, re}, row buffer {im, re}
	logic [96:0] acc_mem [ppa_pkg::ACC_DEPTH];
	logic [31:0] rb_mem  [ppa_pkg::MAX_EIGVECS];
	logic [96:0] acc_rd_q;
	logic [31:0] rb_rd_q;

	logic [47:0] res_re_q, res_im_q;
	logic [1:0]  res_st_q;
	logic        m_tvalid_q;
	logic [103:0] m_tdata_q;

	// pipeline
	logic          v_s1, v_s2, v_s3, v_s4;
	logic          sel_s1, diag_s1;
	logic [IW-1:0] a_s1;
	logic [AW-1:0] addr_s2, addr_s3, addr_s4;
	logic signed [32:0] pr_s2, pi_s2;
	logic signed [49:0] prc_s3, pid_s3, prd_s3, pic_s3;
	logic signed [35:0] tre_s4, tim_s4;
	logic [96:0] old_s4;

	logic signed [15:0] ar, ai, br, bi;
	logic signed [31:0] m_rr, m_ii, m_ri, m_ir;
	logic [AW-1:0] addr_s1;
	logic signed [50:0] xre, xim, rre, rim;
	logic signed [48:0] sre, sim;
	logic signed [47:0] nre, nim;
	logic          ovf_re, ovf_im;
	logic [AW-1:0] rd_addr;
	logic          gen, last_gen, out_free;
	logic [IW:0]   two_j;

	assign clearing = (state_q == S_CLR);
	assign out_free = !m_tvalid_q || m_tready;
	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign two_j    = {cmd_q.col_j, 1'b0};
	assign gen      = (state_q == S_RUN);
	assign last_gen = (k_q == two_j);

	// stage 1: operand select and first products
	always_comb begin
		if (diag_s1) begin
			ar = cmd_q.vr; ai = cmd_q.vi; br = cmd_q.vr; bi = cmd_q.vi;
			addr_s1 = {cmd_q.col_j, cmd_q.col_j};
		end else if (!sel_s1) begin
			ar = rb_rd_q[15:0]; ai = rb_rd_q[31:16]; br = cmd_q.vr; bi = cmd_q.vi;
			addr_s1 = {a_s1, cmd_q.col_j};
		end else begin
			ar = cmd_q.vr; ai = cmd_q.vi; br = rb_rd_q[15:0]; bi = rb_rd_q[31:16];
			addr_s1 = {cmd_q.col_j, a_s1};
		end
		m_rr = ar * br;
		m_ii = ai * bi;
		m_ri = ar * bi;
		m_ir = ai * br;
	end

	// stage 3 rounding, stage 4 saturating add
	always_comb begin
		xre = prc_s3 - pid_s3;
		xim = prd_s3 + pic_s3;
		rre = xre + 51'sd16384;
		rim = xim + 51'sd16384;
		sre = {old_s4[47], old_s4[47:0]} + {{13{tre_s4[35]}}, tre_s4};
		sim = {old_s4[95], old_s4[95:48]} + {{13{tim_s4[35]}}, tim_s4};
		ovf_re = sre[48] != sre[47];
		ovf_im = sim[48] != sim[47];
		nre = ovf_re ? (sre[48] ? ACC_MIN : ACC_MAX) : sre[47:0];
		nim = ovf_im ? (sim[48] ? ACC_MIN : ACC_MAX) : sim[47:0];
		rd_addr = (state_q == S_RD) ? {cmd_q.row, cmd_q.col} : addr_s2;
	end

	always_ff @(posedge clk) begin
		acc_rd_q <= acc_mem[rd_addr];
		rb_rd_q  <= rb_mem[k_q[IW:1]];
		if (q_pop && q_head.kind == ppa_pkg::CMD_LOAD)
			rb_mem[q_head.col_j] <= {q_head.vi, q_head.vr};
		if (state_q == S_CLR)
			acc_mem[clr_cnt_q] <= '0;
		else if (v_s4)
			acc_mem[addr_s4] <= {old_s4[96] | ovf_re | ovf_im, nim, nre};

		sel_s1  <= k_q[0];
		diag_s1 <= last_gen;
		a_s1    <= k_q[IW:1];
		addr_s2 <= addr_s1;
		pr_s2   <= {m_rr[31], m_rr} + {m_ii[31], m_ii};
		pi_s2   <= {m_ri[31], m_ri} - {m_ir[31], m_ir};
		addr_s3 <= addr_s2;
		prc_s3  <= pr_s2 * cmd_q.pc;
		pid_s3  <= pi_s2 * cmd_q.pd;
		prd_s3  <= pr_s2 * cmd_q.pd;
		pic_s3  <= pi_s2 * cmd_q.pc;
		addr_s4 <= addr_s3;
		tre_s4  <= rre[50:15];
		tim_s4  <= rim[50:15];
		old_s4  <= acc_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_cnt_q   <= '0;
			resp_pend_q <= 1'b0;
			k_q         <= '0;
			cmd_q       <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			res_re_q <= '0; res_im_q <= '0; res_st_q <= ppa_pkg::ST_OK;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			v_s1 <= gen;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			// output register: load a new result or drop the one taken
			if (state_q == S_RESP && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready)                 m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cmd_q    <= q_head;
						k_q      <= '0;
						res_re_q <= q_head.one ? 48'sd1073741824 : '0;
						res_im_q <= '0;
						res_st_q <= q_head.status;
						unique case (q_head.kind)
							ppa_pkg::CMD_LOAD: state_q <= S_RUN;
							ppa_pkg::CMD_READ: state_q <= S_RD;
							ppa_pkg::CMD_CLEAR: begin
								clr_cnt_q   <= '0;
								resp_pend_q <= 1'b1;
								state_q     <= S_CLR;
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_RUN: begin
					if (last_gen) state_q <= S_DRAIN;
					else          k_q <= k_q + {{IW{1'b0}}, 1'b1};
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3 && !v_s4) state_q <= S_RESP;
				end
				S_RD: state_q <= S_RDW;
				S_RDW: begin
					res_re_q <= acc_rd_q[47:0];
					res_im_q <= acc_rd_q[95:48];
					res_st_q <= acc_rd_q[96] ? ppa_pkg::ST_SAT : ppa_pkg::ST_OK;
					state_q  <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						m_tdata_q  <= {6'd0, res_st_q, res_im_q, res_re_q};
						state_q    <= S_IDLE;
					end
				end
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + {{(AW-1){1'b0}}, 1'b1};
					if (clr_cnt_q == AW'(ppa_pkg::ACC_DEPTH - 1)) begin
						resp_pend_q <= 1'b0;
						state_q     <= resp_pend_q ? S_RESP : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* sv/phased_projection_accumulator.sv */
// ----------------------------------------------------------------------------
// phased_projection_accumulator
// W = V^H diag(exp(-i 2 pi phi)) V over one timeslice, Q18.30 saturating sums
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes one request per item: s_tuser holds the opcode (load,
//   read, start, no-op), s_tdata the element and the read indexes.
//   m_* channel returns exactly one result per request, in order.
//   cfg_we/cfg_idx/cfg_data write the config registers; write only when idle.
// request handling:
//   a load in column j passes the queue handoff, then issues 2*j+1
//   multiply-accumulates on the one shared pipeline, then the drain and output
//   register before its result; the back pops no new request until the load
//   is done, and this pipeline sets the rate.
//   a read passes the S_RD and S_RDW states on the accumulator memory port;
//   a no-op or an immediate answer goes straight to the result.
//   a start runs a clearing pass over all 4096 accumulator entries, one per
//   cycle, before its result; the same pass follows reset.
//   no request is taken while the clearing pass runs.
// stalls:
//   a two-entry queue sits between the front and the back, and one output
//   register holds a result while the receiver stalls; the back waits then.
// ----------------------------------------------------------------------------
`default_nettype none
module phased_projection_accumulator (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// config write port
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_idx,
	input  wire logic [23:0]   cfg_data,
	// request stream
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [47:0]   s_tdata,   // elem_re, elem_im, row_sel, col_sel
	input  wire logic [1:0]    s_tuser,   // opcode
	// result stream
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [103:0]       m_tdata    // w_re, w_im, status
);
	ppa_pkg::cmd_t push_cmd, head;
	logic q_ready, q_valid, q_pop, clearing, acc;

	// no request while the accumulators are being wiped
	assign s_tready = q_ready && !clearing;
	assign acc      = s_tvalid && s_tready;

	// front: config, counters and phase lookup
	ppa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.acc      (acc),
		.opcode   (s_tuser),
		.elem_re  (s_tdata[15:0]),
		.elem_im  (s_tdata[31:16]),
		.row_sel  (s_tdata[37:32]),
		.col_sel  (s_tdata[43:38]),
		.cmd      (push_cmd)
	);

	// decouples classification from the multiply-accumulate work
	ppa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (acc),
		.push_cmd (push_cmd),
		.ready    (q_ready),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (head)
	);

	// back: accumulator memory and pipeline
	ppa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (head),
		.q_pop    (q_pop),
		.clearing (clearing),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// a push never lands on a full queue
	assert property (@(posedge clk) disable iff (!arst_n) acc |-> q_ready)
		else $error("push into full queue");

	// the clearing pass never overlaps a taken request
	assert property (@(posedge clk) disable iff (!arst_n) clearing |-> !acc)
		else $error("request taken during clearing pass");

	// a pop only happens with something queued
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
endmodule
`default_nettype wire

/* sim/phased_projection_accumulator_tb.sv */
// ----------------------------------------------------------------------------
// phased_projection_accumulator_tb
// self-checking bench: directed and random requests with a built-in predictor
// ----------------------------------------------------------------------------
// a queue of requests feeds a clocked driver; each accepted request is run
// through a bit-exact predictor of the accumulator and its result is queued;
// a clocked monitor compares every result field by field, in order. phases
// change the lattice, phase steps, column count and unity mode while idle.
// ----------------------------------------------------------------------------
`default_nettype none
module phased_projection_accumulator_tb;

	localparam int WATCHDOG_LIMIT = 30000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct {
		logic [1:0]         op;
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic [5:0]         row;
		logic [5:0]         col;
	} request_t;

	typedef struct {
		logic [47:0] re;
		logic [47:0] im;
		logic [1:0]  st;
	} entry_t;

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [2:0]    cfg_idx;
	logic [23:0]   cfg_data;
	logic          s_tvalid;
	logic          s_tready;
	logic [47:0]   s_tdata;   // elem_re, elem_im, row_sel, col_sel
	logic [1:0]    s_tuser;   // opcode
	logic          m_tvalid;
	logic          m_tready;
	logic [103:0]  m_tdata;   // w_re, w_im, status

	phased_projection_accumulator u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// ---------------------------------------------------------------- predictor state
	longint      cos_tab [ppa_pkg::QTR];
	longint      sin_tab [ppa_pkg::QTR];
	logic [23:0] step_x, step_y, step_z;
	logic [6:0]  ext_y, ext_z, nvec;
	logic        unity;
	longint      held_re [ppa_pkg::MAX_EIGVECS];
	longint      held_im [ppa_pkg::MAX_EIGVECS];
	longint      w_re_acc [ppa_pkg::ACC_DEPTH];
	longint      w_im_acc [ppa_pkg::ACC_DEPTH];
	bit          w_sat [ppa_pkg::ACC_DEPTH];
	int          col_cnt, colour_cnt, z_cnt, y_cnt;
	logic [23:0] phase_site, phase_line, phase_plane;

	request_t    pending [$];
	entry_t      results_due [$];
	int          errors;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_off_cycles;

	// quarter-wave cosine/sine, Q30 series rounded half up to Q15
	function automatic longint round_q15(input longint v);
		longint t;
		t = (v < 0) ? 0 : v;
		t = (t + 16384) >>> 15;
		return (t > 32768) ? 64'sd32768 : t;
	endfunction

	function automatic void build_phase_table();
		longint unsigned x, term;
		longint s, c;
		for (int r = 0; r < ppa_pkg::QTR; r++) begin
			x = (64'd1686629713 * 4 * longint'(r)) >> ppa_pkg::PHASE_TABLE_BITS;
			term = x;
			s = longint'(x);
			for (int n = 1; n < 24 && term != 0; n++) begin
				term = ((((term * x) >> 30) * x) >> 30) / longint'((2 * n) * (2 * n + 1));
				s = n[0] ? s - longint'(term) : s + longint'(term);
			end
			term = 64'd1 << 30;
			c = 64'sd1 << 30;
			for (int n = 1; n < 24 && term != 0; n++) begin
				term = ((((term * x) >> 30) * x) >> 30) / longint'((2 * n - 1) * (2 * n));
				c = n[0] ? c - longint'(term) : c + longint'(term);
			end
			cos_tab[r] = round_q15(c);
			sin_tab[r] = round_q15(s);
		end
	endfunction

	function automatic int clamp_range(input logic [6:0] v, input int hi);
		if (v == 7'd0) return 1;
		return (int'(v) > hi) ? hi : int'(v);
	endfunction

	function automatic void clear_sums();
		for (int i = 0; i < ppa_pkg::ACC_DEPTH; i++) begin
			w_re_acc[i] = 0;
			w_im_acc[i] = 0;
			w_sat[i] = 0;
		end
		col_cnt = 0; colour_cnt = 0; z_cnt = 0; y_cnt = 0;
		phase_site = '0; phase_line = '0; phase_plane = '0;
	endfunction

	// saturating 48-bit add with sticky flag
	function automatic void add_sat(input int i, input bit to_im, input longint t);
		longint s;
		s = (to_im ? w_im_acc[i] : w_re_acc[i]) + t;
		if (s > 64'sh7FFFFFFFFFFF) begin s = 64'sh7FFFFFFFFFFF; w_sat[i] = 1; end
		if (s < -64'sh800000000000) begin s = -64'sh800000000000; w_sat[i] = 1; end
		if (to_im) w_im_acc[i] = s; else w_re_acc[i] = s;
	endfunction

	// W[row][col] += conj(a) * (c + i d) * b, term rounded half up to Q2.30
	function automatic void mac_entry(input int row, input int col, input longint ar,
			input longint ai, input longint br, input longint bi, input longint c,
			input longint d);
		longint pr, pq;
		pr = ar * br + ai * bi;
		pq = ar * bi - ai * br;
		add_sat(row * ppa_pkg::MAX_EIGVECS + col, 0, (pr * c - pq * d + 16384) >>> 15);
		add_sat(row * ppa_pkg::MAX_EIGVECS + col, 1, (pr * d + pq * c + 16384) >>> 15);
	endfunction

	function automatic void step_site();
		int ez, ey;
		ez = clamp_range(ext_z, ppa_pkg::MAX_EXTENT);
		ey = clamp_range(ext_y, ppa_pkg::MAX_EXTENT);
		if (z_cnt + 1 < ez) begin
			z_cnt++;
			phase_site = phase_site + step_z;
			return;
		end
		z_cnt = 0;
		if (y_cnt + 1 < ey) begin
			y_cnt++;
			phase_line = phase_line + step_y;
		end else begin
			y_cnt = 0;
			phase_plane = phase_plane + step_x;
			phase_line = phase_plane;
		end
		phase_site = phase_line;
	endfunction

	function automatic void load_element(input longint vr, input longint vi);
		int n, j, r;
		longint sn, c, d;
		logic [9:0] idx;
		n = clamp_range(nvec, ppa_pkg::MAX_EIGVECS);
		if (col_cnt >= n) col_cnt = 0;
		j = col_cnt;
		idx = phase_site[23:14];
		r = int'(idx[7:0]);
		case (idx[9:8])
			2'd0: begin c = cos_tab[r];  sn = sin_tab[r];  end
			2'd1: begin c = -sin_tab[r]; sn = cos_tab[r];  end
			2'd2: begin c = -cos_tab[r]; sn = -sin_tab[r]; end
			default: begin c = sin_tab[r]; sn = -cos_tab[r]; end
		endcase
		d = -sn;
		for (int a = 0; a < j; a++) begin
			mac_entry(a, j, held_re[a], held_im[a], vr, vi, c, d);
			mac_entry(j, a, vr, vi, held_re[a], held_im[a], c, d);
		end
		mac_entry(j, j, vr, vi, vr, vi, c, d);
		held_re[j] = vr;
		held_im[j] = vi;
		if (j + 1 < n) begin col_cnt = j + 1; return; end
		col_cnt = 0;
		if (colour_cnt + 1 < ppa_pkg::COLOURS) begin colour_cnt++; return; end
		colour_cnt = 0;
		step_site();
	endfunction

	function automatic entry_t accumulate_request(input logic [1:0] op, input logic [47:0] data);
		entry_t e;
		int n, r, c;
		e.re = '0; e.im = '0; e.st = ppa_pkg::ST_OK;
		n = clamp_range(nvec, ppa_pkg::MAX_EIGVECS);
		r = int'(data[37:32]);
		c = int'(data[43:38]);
		case (op)
			ppa_pkg::OP_LOAD: if (!unity) load_element(longint'($signed(data[15:0])),
					longint'($signed(data[31:16])));
			ppa_pkg::OP_START: clear_sums();
			ppa_pkg::OP_READ: begin
				if (r >= n || c >= n) e.st = ppa_pkg::ST_RANGE;
				else if (unity) e.re = (r == c) ? 48'd1 << 30 : '0;
				else begin
					e.re = w_re_acc[r * ppa_pkg::MAX_EIGVECS + c][47:0];
					e.im = w_im_acc[r * ppa_pkg::MAX_EIGVECS + c][47:0];
					e.st = w_sat[r * ppa_pkg::MAX_EIGVECS + c] ? ppa_pkg::ST_SAT
						: ppa_pkg::ST_OK;
				end
			end
			default: ;
		endcase
		return e;
	endfunction

	// ---------------------------------------------------------------- driver
	always @(posedge clk or negedge arst_n) begin
		request_t rq;
		logic busy;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= ppa_pkg::OP_NOP;
		end else begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				results_due.push_back(accumulate_request(s_tuser, s_tdata));
				busy = 1'b0;
			end
			if (!busy) begin
				if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					rq = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= rq.op;
					s_tdata  <= {4'd0, rq.col, rq.row, rq.im, rq.re};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk or negedge arst_n) begin
		entry_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					e = results_due.pop_front();
					if (m_tdata[47:0] !== e.re) begin
						$error("w_re expected %0h actual %0h", e.re, m_tdata[47:0]);
						errors++;
					end
					if (m_tdata[95:48] !== e.im) begin
						$error("w_im expected %0h actual %0h", e.im, m_tdata[95:48]);
						errors++;
					end
					if (m_tdata[97:96] !== e.st) begin
						$error("status expected %0d actual %0d", e.st, m_tdata[97:96]);
						errors++;
					end
				end
			end
			// long hold-off lets the input side back up
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		int quiet;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
		else quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus
	function automatic void push_request(input logic [1:0] op, input int re, input int im,
			input int row, input int col);
		request_t rq;
		rq.op = op; rq.re = re[15:0]; rq.im = im[15:0]; rq.row = row[5:0]; rq.col = col[5:0];
		pending.push_back(rq);
	endfunction

	function automatic int rand_elem();
		case ($urandom_range(7))
			0: return -32768;
			1: return 32767;
			default: return int'($signed(16'($urandom())));
		endcase
	endfunction

	// random loads with reads, a few starts and noise between
	function automatic void push_random(input int count);
		int n;
		n = clamp_range(nvec, ppa_pkg::MAX_EIGVECS);
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(99)) inside
				[0:59]: push_request(ppa_pkg::OP_LOAD, rand_elem(), rand_elem(), 0, 0);
				[60:86]: push_request(ppa_pkg::OP_READ, 0, 0, $urandom_range(n - 1),
						$urandom_range(n - 1));
				[87:92]: push_request(ppa_pkg::OP_READ, rand_elem(), rand_elem(),
						$urandom_range(63), $urandom_range(63));
				[93:97]: push_request(ppa_pkg::OP_NOP, rand_elem(), rand_elem(),
						$urandom_range(63), $urandom_range(63));
				default: push_request(($urandom_range(3) == 0) ? ppa_pkg::OP_START
						: ppa_pkg::OP_LOAD, rand_elem(), rand_elem(), 0, 0);
			endcase
		end
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		case (idx)
			ppa_pkg::CFG_STEP_X: step_x = value;
			ppa_pkg::CFG_STEP_Y: step_y = value;
			ppa_pkg::CFG_STEP_Z: step_z = value;
			ppa_pkg::CFG_EXT_Y:  ext_y  = value[6:0];
			ppa_pkg::CFG_EXT_Z:  ext_z  = value[6:0];
			ppa_pkg::CFG_NVEC:   nvec   = value[6:0];
			ppa_pkg::CFG_UNITY:  unity  = value[0];
			default: ;
		endcase
	endtask

	task automatic setup(input logic [23:0] sx, input logic [23:0] sy, input logic [23:0] sz,
			input int ey, input int ez, input int n, input bit u);
		write_reg(ppa_pkg::CFG_STEP_X, sx);
		write_reg(ppa_pkg::CFG_STEP_Y, sy);
		write_reg(ppa_pkg::CFG_STEP_Z, sz);
		write_reg(ppa_pkg::CFG_EXT_Y, 24'(ey));
		write_reg(ppa_pkg::CFG_EXT_Z, 24'(ez));
		write_reg(ppa_pkg::CFG_NVEC, 24'(n));
		write_reg(ppa_pkg::CFG_UNITY, {23'd0, u});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until the block has taken and answered everything
	task automatic drain();
		while (pending.size() > 0 || s_tvalid || results_due.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		errors = 0;
		hold_off_cycles = 0;
		send_idle_pct = 29;
		recv_idle_pct = 55;
		cfg_we = 1'b0;
		cfg_idx = ppa_pkg::CFG_STEP_X;
		cfg_data = '0;
		step_x = '0; step_y = '0; step_z = '0;
		ext_y = 7'd1; ext_z = 7'd1; nvec = 7'd1; unity = 1'b0;
		build_phase_table();
		clear_sums();
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every opcode, out-of-range reads, stale column
		setup(24'h800000, 24'h7FFFFF, 24'h400000, 2, 2, 4, 0);
		push_request(ppa_pkg::OP_READ, 0, 0, 0, 0);
		push_request(ppa_pkg::OP_LOAD, -32768, -32768, 0, 0);
		push_request(ppa_pkg::OP_LOAD, 32767, 32767, 0, 0);
		push_request(ppa_pkg::OP_LOAD, -32768, 32767, 0, 0);
		push_request(ppa_pkg::OP_LOAD, 32767, -32768, 0, 0);
		push_request(ppa_pkg::OP_READ, 0, 0, 0, 3);
		push_request(ppa_pkg::OP_READ, 0, 0, 3, 3);
		push_request(ppa_pkg::OP_READ, 0, 0, 4, 0);
		push_request(ppa_pkg::OP_READ, 0, 0, 0, 63);
		push_request(ppa_pkg::OP_READ, 0, 0, 63, 63);
		push_request(ppa_pkg::OP_NOP, -1, -1, 63, 63);
		push_request(ppa_pkg::OP_LOAD, 12345, -2222, 0, 0);
		push_request(ppa_pkg::OP_LOAD, -7, 9, 0, 0);
		drain();
		// lowered column count leaves the row stale, lowered extents wrap
		setup(24'h123456, 24'hFEDCBA, 24'h000001, 1, 1, 1, 0);
		push_request(ppa_pkg::OP_LOAD, 1000, 2000, 0, 0);
		push_request(ppa_pkg::OP_READ, 0, 0, 0, 0);
		push_request(ppa_pkg::OP_START, 0, 0, 0, 0);
		push_request(ppa_pkg::OP_READ, 0, 0, 0, 0);
		drain();
		setup(24'h000000, 24'h000000, 24'h000000, 0, 0, 0, 1);
		push_request(ppa_pkg::OP_LOAD, 500, 500, 0, 0);
		push_request(ppa_pkg::OP_READ, 0, 0, 0, 0);
		push_request(ppa_pkg::OP_READ, 0, 0, 0, 1);
		push_request(ppa_pkg::OP_START, 0, 0, 0, 0);
		drain();

		// random phases, receiver-heavy idling first
		setup(24'($urandom()), 24'($urandom()), 24'($urandom()), 3, 4, 3, 0);
		push_random(140);
		drain();
		// input backs up while the receiver holds off
		setup(24'($urandom()), 24'($urandom()), 24'($urandom()), 2, 3, 6, 0);
		hold_off_cycles = 400;
		push_random(130);
		drain();

		send_idle_pct = 55;
		recv_idle_pct = 29;
		setup(24'h7FFFFF, 24'h800000, 24'($urandom()), 64, 64, 2, 0);
		push_random(130);
		drain();
		setup(24'($urandom()), 24'($urandom()), 24'($urandom()), 127, 5, 127, 0);
		for (int k = 0; k < 64; k++)
			push_request(ppa_pkg::OP_LOAD, rand_elem(), rand_elem(), 0, 0);
		push_random(60);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		setup(24'($urandom()), 24'($urandom()), 24'($urandom()), 2, 2, 5, 1);
		push_random(60);
		drain();
		setup(24'($urandom()), 24'($urandom()), 24'($urandom()), 1, 2, 8, 0);
		push_random(190);
		drain();

		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
